/* rtl/core/gbn_pkg.sv */
package gbn_pkg;

  localparam int MAX_SEQ_BITS = 4;
  localparam int DATA_WIDTH   = 32;
  localparam int SEQ_W        = MAX_SEQ_BITS;
  localparam int BUF_DEPTH    = 1 << MAX_SEQ_BITS;
  localparam int TICK_W       = 16;
  localparam int SBITS_W      = 3;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_NAK  = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_SENT        = 3'd0,
    K_RESENT      = 3'd1,
    K_FULL        = 3'd2,
    K_ACK_TAKEN   = 3'd3,
    K_ACK_IGNORED = 3'd4,
    K_TICK_IDLE   = 3'd5,
    K_NOTHING     = 3'd6
  } kind_t;

  typedef enum logic {
    CFG_SEQ_BITS = 1'b0,
    CFG_TIMEOUT  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RS_READ,
    ST_RS_EMIT
  } state_t;

  typedef struct packed {
    logic latch;  // capture the input beat
    logic exec;   // carry out the captured item
    logic rd;     // read the next copy for a resend
    logic emit;   // load the resent frame into the output register
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic resend_go;
    logic rs_last;
  } status_t;

  // Sequence mask for the effective width: 0 acts as 1, above max clamps.
  function automatic logic [SEQ_W-1:0] seq_mask(input logic [SBITS_W-1:0] bits);
    logic [SBITS_W-1:0] eff;
    logic [SEQ_W:0]     m;
    eff = bits;
    if (eff == '0) eff = SBITS_W'(1);
    if (eff > SBITS_W'(MAX_SEQ_BITS)) eff = SBITS_W'(MAX_SEQ_BITS);
    m = (SEQ_W+1)'(1) << eff;
    return SEQ_W'(m - (SEQ_W+1)'(1));
  endfunction

endpackage

/* rtl/core/gbn_ctrl.sv */
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.slot_free) begin
          cmd.exec   = 1'b1;
          state_next = status.resend_go ? ST_RS_READ : ST_IDLE;
        end
      end
      ST_RS_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_RS_EMIT;
      end
      ST_RS_EMIT: begin
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = status.rs_last ? ST_IDLE : ST_RS_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/gbn_datapath.sv */
module gbn_datapath
  import gbn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [TICK_W-1:0]     cfg_data,
  input  logic [1:0]            opcode,
  input  logic [DATA_WIDTH-1:0] payload,
  input  logic [3:0]            ack_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            kind,
  output logic [3:0]            frame_seq,
  output logic [DATA_WIDTH-1:0] frame_data,
  output logic                  last
);

  logic [DATA_WIDTH-1:0] copy_mem [BUF_DEPTH];

  logic [SBITS_W-1:0]    seq_bits;
  logic [TICK_W-1:0]     timeout_ticks;
  logic [SEQ_W-1:0]      base_seq, base_seq_next;
  logic [SEQ_W-1:0]      next_seq, next_seq_next;
  logic [SEQ_W-1:0]      outstanding, outstanding_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;

  op_t                   op_q;
  logic [DATA_WIDTH-1:0] payload_q;
  logic [3:0]            ack_q;
  logic [SEQ_W-1:0]      rs_seq;
  logic [SEQ_W-1:0]      rs_k;
  logic [DATA_WIDTH-1:0] rd_data;

  logic [SEQ_W-1:0]      mask;
  logic [SEQ_W-1:0]      send_seq;
  logic [SEQ_W-1:0]      base_inc;
  logic                  window_full;
  logic                  ack_ok;
  logic [TICK_W-1:0]     tick_inc;
  logic [TICK_W-1:0]     limit;
  logic                  tick_fire;
  logic                  resend_req;
  logic                  mem_we;

  logic                  out_load;
  kind_t                 res_kind;
  logic [SEQ_W-1:0]      res_seq;
  logic [DATA_WIDTH-1:0] res_data;
  logic                  res_last;

  always_comb begin
    mask        = seq_mask(seq_bits);
    send_seq    = next_seq & mask;
    base_inc    = (base_seq + SEQ_W'(1)) & mask;
    window_full = (outstanding >= mask);
    ack_ok      = (outstanding != '0) && (ack_q == 4'(base_inc));
    tick_inc    = tick_count + TICK_W'(1);
    limit       = (timeout_ticks == '0) ? TICK_W'(1) : timeout_ticks;
    tick_fire   = (tick_inc >= limit);
    resend_req  = (op_q == OP_NAK) || ((op_q == OP_TICK) && tick_fire);
  end

  assign status.slot_free = !out_valid || out_ready;
  assign status.resend_go = resend_req && (outstanding != '0);
  assign status.rs_last   = ({1'b0, rs_k} + (SEQ_W+1)'(1)) == {1'b0, outstanding};

  always_comb begin
    base_seq_next    = base_seq;
    next_seq_next    = next_seq;
    outstanding_next = outstanding;
    tick_count_next  = tick_count;
    mem_we           = 1'b0;
    out_load         = 1'b0;
    res_kind         = K_NOTHING;
    res_seq          = '0;
    res_data         = '0;
    res_last         = 1'b1;
    if (cmd.exec) begin
      unique case (op_q)
        OP_SEND: begin
          out_load = 1'b1;
          if (window_full) begin
            res_kind = K_FULL;
          end else begin
            mem_we           = 1'b1;
            if (outstanding == '0) tick_count_next = '0;
            outstanding_next = outstanding + SEQ_W'(1);
            next_seq_next    = (send_seq + SEQ_W'(1)) & mask;
            res_kind         = K_SENT;
            res_seq          = send_seq;
            res_data         = payload_q;
          end
        end
        OP_ACK: begin
          out_load = 1'b1;
          if (ack_ok) begin
            base_seq_next    = base_inc;
            outstanding_next = outstanding - SEQ_W'(1);
            tick_count_next  = '0;
            res_kind         = K_ACK_TAKEN;
          end else begin
            res_kind = K_ACK_IGNORED;
          end
        end
        OP_NAK, OP_TICK: begin
          if (resend_req) begin
            tick_count_next = '0;
            // nothing outstanding: one marker result, else hand over to the walk
            out_load = (outstanding == '0);
          end else begin
            tick_count_next = tick_inc;
            out_load        = 1'b1;
            res_kind        = K_TICK_IDLE;
          end
        end
        default: ;
      endcase
    end else if (cmd.emit) begin
      out_load = 1'b1;
      res_kind = K_RESENT;
      res_seq  = rs_seq;
      res_data = rd_data;
      res_last = status.rs_last;
    end
    if (cfg_we && (cfg_index == CFG_SEQ_BITS)) begin
      // width change empties the window
      base_seq_next    = '0;
      next_seq_next    = '0;
      outstanding_next = '0;
      tick_count_next  = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_bits      <= SBITS_W'(3);
      timeout_ticks <= TICK_W'(10);
      base_seq      <= '0;
      next_seq      <= '0;
      outstanding   <= '0;
      tick_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      base_seq    <= base_seq_next;
      next_seq    <= next_seq_next;
      outstanding <= outstanding_next;
      tick_count  <= tick_count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_SEQ_BITS) begin
          seq_bits <= cfg_data[SBITS_W-1:0];
        end else begin
          timeout_ticks <= cfg_data;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q      <= op_t'(opcode);
      payload_q <= payload;
      ack_q     <= ack_number;
    end
    if (cmd.exec) begin
      rs_k   <= '0;
      rs_seq <= base_seq;
    end else if (cmd.emit) begin
      rs_k   <= rs_k + SEQ_W'(1);
      rs_seq <= (rs_seq + SEQ_W'(1)) & mask;
    end
    if (out_load) begin
      kind       <= res_kind;
      frame_seq  <= 4'(res_seq);
      frame_data <= res_data;
      last       <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      copy_mem[send_seq] <= payload_q;
    end
    if (cmd.rd) begin
      rd_data <= copy_mem[rs_seq];
    end
  end

endmodule

/* rtl/core/go_back_n_sender_window.sv */
// Go-Back-N sender window.
// Input channel (in_valid/in_ready) takes one beat per item: opcode, payload
// and ack_number. Output channel (out_valid/out_ready) gives result beats:
// kind, frame_seq, frame_data and last, with last high on the final beat of
// an item. Configuration is a plain write port (cfg_we, cfg_index, cfg_data):
// index 0 is seq_bits, index 1 is timeout_ticks; write it only while idle.
// Send, ack and non-firing tick items load their one beat into the output
// register from ST_EXEC once the output register is free; the block then
// returns to idle, so it takes no new item before the last is done. A resend
// (NAK or timer expiry) walks the copy buffer, one frame per ST_RS_READ and
// ST_RS_EMIT pair, as the copy memory is read through a register. The walk
// covers the outstanding frames from base_seq. The next input is taken
// only once the last beat of an item sits in the output register.
// A stalled receiver holds the output register and the block waits on it.
// Reset empties the window, clears the timer and sets seq_bits to 3 and
// timeout_ticks to 10; the copy buffer is not cleared.
module go_back_n_sender_window
  import gbn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            opcode,
  input  logic [DATA_WIDTH-1:0] payload,
  input  logic [3:0]            ack_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            kind,
  output logic [3:0]            frame_seq,
  output logic [DATA_WIDTH-1:0] frame_data,
  output logic                  last,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [TICK_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gbn_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .opcode     (opcode),
    .payload    (payload),
    .ack_number (ack_number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .frame_seq  (frame_seq),
    .frame_data (frame_data),
    .last       (last)
  );

endmodule
